// ===== hw/rtl/hlfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlfr_pkg
// Shared types and constants for the header/length frame receiver.
// ----------------------------------------------------------------------------
package hlfr_pkg;

    localparam int MAX_FRAME   = 1024;
    localparam int ADDR_W      = $clog2(MAX_FRAME);
    localparam int COUNT_W     = $clog2(MAX_FRAME + 1);
    localparam int LEN_W       = 11;
    localparam int HDR_LEN     = 6;
    localparam int LEN_HI_POS  = 6;
    localparam int LEN_END_POS = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN   = 1'b1;

    localparam logic [LEN_W-1:0] MIN_LEN_RESET = LEN_W'(26);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_COLLECT    = 3'd0,
        ST_READY      = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_TOO_BIG    = 3'd3,
        ST_OVERFLOW   = 3'd4,
        ST_TOO_SHORT  = 3'd5
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [7:0]        rx_byte;
        logic [ADDR_W-1:0] read_index;
    } in_word_t;

    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       read_data;
    } out_word_t;

    // Command passed from the classifier to the store side
    typedef struct packed {
        logic              is_read;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wr_data;
        status_t           status;
        logic [LEN_W-1:0]  frame_length;
    } cmd_t;

    // Sync header "baiyue"
    function automatic logic [7:0] sync_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'h62;
            3'd1:    b = 8'h61;
            3'd2:    b = 8'h69;
            3'd3:    b = 8'h79;
            3'd4:    b = 8'h75;
            3'd5:    b = 8'h65;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hlfr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlfr_front
// Accepts words, tracks the frame in progress and classifies each push.
// ----------------------------------------------------------------------------
module hlfr_front import hlfr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    input  wire in_word_t              s_data,
    input  wire logic                  cmd_ready,
    output cmd_t                       cmd,
    output logic                       cmd_valid
);

    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [LEN_W-1:0]   decl_reg,    decl_next;
    logic               hdr_ok_reg,  hdr_ok_next;
    logic [7:0]         byte6_reg,   byte6_next;
    logic               low_first_reg;
    logic [LEN_W-1:0]   min_len_reg;

    logic               push;
    logic [COUNT_W-1:0] count_inc;
    logic               hdr_match;
    logic [15:0]        len_word;
    logic [LEN_W-1:0]   decl_eff;
    status_t            push_status;
    logic [LEN_W-1:0]   push_len;
    logic               restart;

    assign cmd_valid = s_valid;
    assign push      = s_valid && cmd_ready && (s_data.op == OP_PUSH);
    assign count_inc = count_reg + COUNT_W'(1);

    always_comb begin
        hdr_match = ((count_reg == '0) ? 1'b1 : hdr_ok_reg)
                    && (s_data.rx_byte == sync_byte(count_reg[2:0]));
        len_word  = low_first_reg ? {s_data.rx_byte, byte6_reg}
                                  : {byte6_reg, s_data.rx_byte};
        decl_eff  = decl_reg;
        if (count_inc == COUNT_W'(LEN_END_POS)) begin
            decl_eff = len_word[LEN_W-1:0];
        end

        push_status = ST_COLLECT;
        push_len    = '0;
        restart     = 1'b0;
        if (count_reg == COUNT_W'(MAX_FRAME)) begin
            push_status = ST_OVERFLOW;
            restart     = 1'b1;
        end else if (count_inc == COUNT_W'(HDR_LEN) && !hdr_match) begin
            push_status = ST_BAD_HEADER;
            restart     = 1'b1;
        end else if (count_inc == COUNT_W'(LEN_END_POS)
                     && len_word > 16'(MAX_FRAME)) begin
            push_status = ST_TOO_BIG;
            restart     = 1'b1;
        end else if (LEN_W'(count_inc) == decl_eff) begin
            restart = 1'b1;
            if (LEN_W'(count_inc) < min_len_reg) begin
                push_status = ST_TOO_SHORT;
            end else begin
                push_status = ST_READY;
                push_len    = LEN_W'(count_inc);
            end
        end

        count_next  = count_reg;
        decl_next   = decl_reg;
        hdr_ok_next = hdr_ok_reg;
        byte6_next  = byte6_reg;
        if (push) begin
            if (count_reg < COUNT_W'(HDR_LEN)) begin
                hdr_ok_next = hdr_match;
            end
            if (count_reg == COUNT_W'(LEN_HI_POS)) begin
                byte6_next = s_data.rx_byte;
            end
            if (restart) begin
                count_next = '0;
                decl_next  = '0;
            end else begin
                count_next = count_inc;
                decl_next  = decl_eff;
            end
        end

        cmd.is_read = (s_data.op == OP_READ);
        if (s_data.op == OP_READ) begin
            cmd.addr         = s_data.read_index;
            cmd.status       = ST_COLLECT;
            cmd.frame_length = '0;
        end else begin
            cmd.addr         = count_reg[ADDR_W-1:0];
            cmd.status       = push_status;
            cmd.frame_length = push_len;
        end
        cmd.wr_data = s_data.rx_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            decl_reg      <= '0;
            hdr_ok_reg    <= 1'b0;
            low_first_reg <= 1'b0;
            min_len_reg   <= MIN_LEN_RESET;
        end else begin
            count_reg  <= count_next;
            decl_reg   <= decl_next;
            hdr_ok_reg <= hdr_ok_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_LOW_FIRST: low_first_reg <= cfg_data[0];
                    CFG_MIN_LEN:   min_len_reg   <= LEN_W'(cfg_data);
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte6_reg <= byte6_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hlfr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlfr_queue
// Short command queue between the classifier and the store side.
// ----------------------------------------------------------------------------
module hlfr_queue import hlfr_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;
    logic                do_push, do_pop;

    assign push_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wptr_next = do_push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next = do_pop  ? rptr_reg + QPTR_W'(1) : rptr_reg;
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hlfr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlfr_back
// Frame store and output register: writes pushed bytes, serves reads.
// ----------------------------------------------------------------------------
module hlfr_back import hlfr_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_word_t m_data
);

    logic [7:0]       store_reg [MAX_FRAME];
    logic [7:0]       rd_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_is_read_reg;
    status_t          out_status_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             take;

    assign cmd_ready = !out_valid_reg || m_ready;
    assign take      = cmd_valid && cmd_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // rejected overflow byte is not stored
    always_ff @(posedge aclk) begin
        if (take) begin
            if (cmd.is_read) begin
                rd_data_reg <= store_reg[cmd.addr];
            end else if (cmd.status != ST_OVERFLOW) begin
                store_reg[cmd.addr] <= cmd.wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_is_read_reg <= cmd.is_read;
            out_status_reg  <= cmd.status;
            out_len_reg     <= cmd.frame_length;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_data.status       = out_status_reg;
    assign m_data.frame_length = out_len_reg;
    assign m_data.read_data    = out_is_read_reg ? rd_data_reg : 8'h00;

endmodule
`default_nettype wire

// ===== hw/rtl/header_length_frame_receiver_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// header_length_frame_receiver_core
// Byte-wise frame receiver: sync header check, length field, frame store.
//
//   Channel  Dir  Handshake              Word
//   s_       in   s_valid / s_ready      in_word_t (op, rx_byte, read_index)
//   m_       out  m_valid / m_ready      out_word_t (status, frame_length,
//                                        read_data)
//   cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained unless the output stalls; each accepted word
// passes through the four-entry queue, then the store access into the output
// register; the classifier is combinational.
// The single-port 1024 x 8 frame store sets the one-access-per-cycle rate.
// Reset clears frame tracking and the configuration registers; the store is not cleared.
// A stalled output fills the queue, then s_ready drops; cfg_ready is tied high.
// ----------------------------------------------------------------------------
module header_length_frame_receiver_core import hlfr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t front_cmd;
    logic front_valid;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    assign cfg_ready = 1'b1;

    hlfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .cmd_ready (s_ready),
        .cmd       (front_cmd),
        .cmd_valid (front_valid)
    );

    hlfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (s_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    hlfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_len_only_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_READY |-> m_data.frame_length == '0)
        else $error("frame_length set without frame ready");

    a_ready_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_READY |->
            m_data.frame_length >= LEN_W'(LEN_END_POS)
            && m_data.frame_length <= LEN_W'(MAX_FRAME))
        else $error("frame ready with impossible length");

    a_data_only_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_COLLECT |-> m_data.read_data == 8'h00)
        else $error("read_data set on a push result");

    a_queue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> back_valid)
        else $error("input stalled with empty queue");

endmodule
`default_nettype wire

// ===== verif/hlfr_frame_checker.sv =====
// ----------------------------------------------------------------------------
// hlfr_frame_checker
// Watches the input, result and register channels of the frame receiver.
// Every accepted input word runs through a local model of the sync header
// check, length field decode and frame store. Every accepted result word is
// compared field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module hlfr_frame_checker import hlfr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire in_word_t              s_data,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire out_word_t             m_data,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         outstanding,
    output int                         written_hi,
    output int                         results_checked,
    output int                         frames_done,
    output int                         frames_dropped
);

    localparam logic [47:0] SYNC_WORD = "baiyue";

    logic [7:0]       store_img [MAX_FRAME];
    int unsigned      held;
    logic [15:0]      length_field;
    logic             low_first;
    logic [LEN_W-1:0] min_len;
    int               store_hi;
    int               errors;
    int               checked;
    int               done;
    int               dropped;
    out_word_t        expected_q [$];

    function automatic out_word_t receive_word(input in_word_t w);
        out_word_t   r;
        logic [15:0] len;
        logic        hdr_ok;
        r.status       = ST_COLLECT;
        r.frame_length = '0;
        r.read_data    = '0;
        if (w.op == OP_READ) begin
            r.read_data = store_img[w.read_index];
            return r;
        end
        if (held >= MAX_FRAME) begin
            held = 0;
            length_field = '0;
            r.status = ST_OVERFLOW;
            return r;
        end
        store_img[held] = w.rx_byte;
        held++;
        if (held > store_hi)
            store_hi = held;
        if (held == HDR_LEN) begin
            hdr_ok = 1'b1;
            for (int i = 0; i < HDR_LEN; i++)
                if (store_img[i] != SYNC_WORD[47 - 8*i -: 8])
                    hdr_ok = 1'b0;
            if (!hdr_ok) begin
                held = 0;
                length_field = '0;
                r.status = ST_BAD_HEADER;
                return r;
            end
        end
        if (held == LEN_END_POS) begin
            len = low_first ? {store_img[7], store_img[6]} : {store_img[6], store_img[7]};
            if (len > MAX_FRAME) begin
                held = 0;
                length_field = '0;
                r.status = ST_TOO_BIG;
                return r;
            end
            length_field = len;
        end
        if (held == length_field) begin
            if (held < min_len) begin
                r.status = ST_TOO_SHORT;
            end else begin
                r.status = ST_READY;
                r.frame_length = LEN_W'(held);
            end
            held = 0;
            length_field = '0;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            held = 0;
            length_field = '0;
            low_first = 1'b0;
            min_len = MIN_LEN_RESET;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected: status %0d, length %0d, data %0d",
                           m_data.status, m_data.frame_length, m_data.read_data);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (want.status == ST_READY)
                        done++;
                    else if (want.status != ST_COLLECT)
                        dropped++;
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_data.status);
                        errors++;
                    end
                    if (m_data.frame_length !== want.frame_length) begin
                        $error("frame_length: expected %0d, actual %0d",
                               want.frame_length, m_data.frame_length);
                        errors++;
                    end
                    if (m_data.read_data !== want.read_data) begin
                        $error("read_data: expected %0d, actual %0d",
                               want.read_data, m_data.read_data);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LOW_FIRST: low_first = cfg_data[0];
                    CFG_MIN_LEN:   min_len = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_q.push_back(receive_word(s_data));
        end
        fail_count      <= errors;
        outstanding     <= expected_q.size();
        written_hi      <= store_hi;
        results_checked <= checked;
        frames_done     <= done;
        frames_dropped  <= dropped;
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for header_length_frame_receiver_core. Drives good,
// short, oversized, corrupted and runaway frames with interleaved store reads
// under both byte orders and a range of minimum lengths, with random idling
// on both channels and a long output stall; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
    import hlfr_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          LONG_HOLD    = 400;
    localparam int          SETTLE       = 8;
    localparam int          RANDOM_WORDS = 450;
    localparam logic [47:0] SYNC_WORD    = "baiyue";

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_HEADER,
        FRAME_TOO_BIG,
        FRAME_NOISE,
        FRAME_RUNAWAY
    } frame_kind_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    in_word_t              s_data       = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    out_word_t             m_data;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  hold_request = 1'b0;

    int fail_count;
    int outstanding;
    int written_hi;
    int results_checked;
    int frames_done;
    int frames_dropped;
    int cycle_count   = 0;
    int words_sent    = 0;
    bit sender_idles  = 1'b1;
    bit reads_on      = 1'b0;
    bit cur_low_first = 1'b0;

    header_length_frame_receiver_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hlfr_frame_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .written_hi      (written_hi),
        .results_checked (results_checked),
        .frames_done     (frames_done),
        .frames_dropped  (frames_dropped)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // result side: random ready, long hold on request
    initial begin
        int run_len;
        int stall_len;
        forever begin
            if (hold_request) begin
                hold_request <= 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 8);
                m_ready <= 1'b1;
                repeat (run_len) @(posedge aclk);
                stall_len = 0;
                if ($urandom_range(0, 1) == 0)
                    stall_len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
                if (stall_len > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall_len) @(posedge aclk);
                end
            end
        end
    end

    function automatic int pick_gap();
        if (!sender_idles || $urandom_range(0, 2) != 0)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic put_word(input in_word_t w);
        int gap;
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic read_byte(input int idx);
        in_word_t w;
        w.op         = OP_READ;
        w.rx_byte    = 8'($urandom_range(0, 255));
        w.read_index = ADDR_W'(idx);
        put_word(w);
    endtask

    task automatic push_byte(input logic [7:0] b);
        in_word_t w;
        if (reads_on && written_hi > 0 && $urandom_range(0, 5) == 0)
            read_byte($urandom_range(0, written_hi - 1));
        w.op         = OP_PUSH;
        w.rx_byte    = b;
        w.read_index = ADDR_W'($urandom_range(0, MAX_FRAME - 1));
        put_word(w);
    endtask

    // arg: length field, or the corrupted header position for a bad header
    task automatic send_frame(input frame_kind_t kind, input int arg);
        logic [7:0]  bytes [$];
        logic [15:0] len;
        int          total;
        len = arg[15:0];
        for (int i = 0; i < HDR_LEN; i++)
            bytes.push_back(SYNC_WORD[47 - 8*i -: 8]);
        case (kind)
            FRAME_NOISE: begin
                foreach (bytes[i])
                    bytes[i] = 8'($urandom_range(0, 255));
                if (bytes[HDR_LEN-1] == SYNC_WORD[7:0])
                    bytes[HDR_LEN-1] ^= 8'h01;
            end
            FRAME_BAD_HEADER: begin
                bytes[arg] ^= 8'($urandom_range(1, 255));
            end
            default: begin
                if (cur_low_first) begin
                    bytes.push_back(len[7:0]);
                    bytes.push_back(len[15:8]);
                end else begin
                    bytes.push_back(len[15:8]);
                    bytes.push_back(len[7:0]);
                end
                total = (kind == FRAME_GOOD)    ? arg :
                        (kind == FRAME_RUNAWAY) ? MAX_FRAME + 1 : LEN_END_POS;
                while (bytes.size() < total)
                    bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        foreach (bytes[i])
            push_byte(bytes[i]);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_LOW_FIRST)
            cur_low_first = value[0];
    endtask

    task automatic set_config(input int low_first, input int min_length);
        write_reg(CFG_LOW_FIRST, low_first);
        write_reg(CFG_MIN_LEN, min_length);
    endtask

    task automatic random_phase(input int quota, input int min_length);
        int first;
        int pick;
        int len;
        first = words_sent;
        while (words_sent - first < quota) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) begin
                if (min_length <= 64 && $urandom_range(0, 2) == 0)
                    len = min_length - 1 + $urandom_range(0, 2);
                else
                    len = $urandom_range(8, 48);
                if (len < LEN_END_POS)
                    len = LEN_END_POS;
                send_frame(FRAME_GOOD, len);
            end else if (pick < 14) begin
                send_frame(FRAME_BAD_HEADER, $urandom_range(0, HDR_LEN - 1));
            end else if (pick < 16) begin
                send_frame(FRAME_TOO_BIG, $urandom_range(MAX_FRAME + 1, 16'hFFFF));
            end else if (pick < 19) begin
                send_frame(FRAME_NOISE, 0);
            end else begin
                drain();
            end
        end
    endtask

    initial begin
        int random_start;
        int phase_no;
        int min_length;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset register values: high byte first, minimum 26
        send_frame(FRAME_BAD_HEADER, HDR_LEN - 1);
        send_frame(FRAME_TOO_BIG, 16'hFFFF);
        send_frame(FRAME_GOOD, LEN_END_POS);
        read_byte(0);
        read_byte(7);
        drain();

        set_config(1, 8);
        send_frame(FRAME_GOOD, LEN_END_POS);
        send_frame(FRAME_TOO_BIG, MAX_FRAME + 1);
        send_frame(FRAME_GOOD, MAX_FRAME - 1);
        drain();

        set_config(0, MAX_FRAME);
        send_frame(FRAME_GOOD, MAX_FRAME);
        send_frame(FRAME_GOOD, 9);
        drain();

        // declared length under eight runs on to overflow, output held off
        reads_on = 1'b1;
        sender_idles = 1'b0;
        hold_request <= 1'b1;
        send_frame(FRAME_RUNAWAY, $urandom_range(0, 7));
        drain();

        random_start = words_sent;
        phase_no = 0;
        while (words_sent - random_start < RANDOM_WORDS) begin
            case ($urandom_range(0, 3))
                0:       min_length = 8;
                1:       min_length = 26;
                2:       min_length = $urandom_range(9, 64);
                default: min_length = MAX_FRAME;
            endcase
            set_config($urandom_range(0, 1), min_length);
            sender_idles = ($urandom_range(0, 3) != 0);
            if (phase_no == 0) begin
                sender_idles = 1'b0;
                hold_request <= 1'b1;
            end
            random_phase(90, min_length);
            drain();
            phase_no++;
        end

        $display("Covered %0d input words and %0d results: %0d frames completed, %0d dropped",
                 words_sent, results_checked, frames_done, frames_dropped);
        $display("Both length byte orders, minimum length from 8 to %0d, %0d random phases",
                 MAX_FRAME, phase_no);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hlfr_pkg.sv
hw/rtl/hlfr_front.sv
hw/rtl/hlfr_queue.sv
hw/rtl/hlfr_back.sv
hw/rtl/header_length_frame_receiver_core.sv
verif/hlfr_frame_checker.sv
verif/tb.sv
